>>> hw/rtl/scl_pkg.sv
// scl_pkg: shared types, control byte codes and the fixed command table
// for the serial command line matcher; no dependencies
package scl_pkg;

    localparam int BYTE_W        = 8;
    localparam int NUM_CMDS      = 14;
    localparam int CMD_MAX_CHARS = 10;
    localparam int CMD_IDX_W     = 4;
    localparam int CMD_LEN_W     = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_DEL = 8'h7F;

    // what the back end does with an item
    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_DEL,
        KIND_EOL
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [CMD_IDX_W-1:0] command_index;
        logic                 matched;
    } result_t;

    function automatic logic [CMD_LEN_W-1:0] cmd_len(input int k);
        logic [CMD_LEN_W-1:0] n;
        begin
            case (k)
                0:       n = 4'd5;
                1:       n = 4'd10;
                2:       n = 4'd1;
                3:       n = 4'd8;
                4:       n = 4'd10;
                5:       n = 4'd9;
                6:       n = 4'd9;
                7:       n = 4'd1;
                8:       n = 4'd1;
                9:       n = 4'd1;
                10:      n = 4'd1;
                11:      n = 4'd4;
                12:      n = 4'd8;
                13:      n = 4'd4;
                default: n = '0;
            endcase
            return n;
        end
    endfunction

    // character i of command k, valid for i below cmd_len(k)
    function automatic logic [BYTE_W-1:0] cmd_char(input int k, input int i);
        logic [BYTE_W*CMD_MAX_CHARS-1:0] s;
        int                               pos;
        begin
            case (k)
                0:       s = "Reset";
                1:       s = "Get Sample";
                2:       s = "G";
                3:       s = "Init ADC";
                4:       s = "Status ADC";
                5:       s = "Calib ADC";
                6:       s = "Reset ADC";
                7:       s = "4";
                8:       s = "1";
                9:       s = "5";
                10:      s = "2";
                11:      s = "Time";
                12:      s = "Set UART";
                13:      s = "Help";
                default: s = '0;
            endcase
            // string literals are right aligned, last character in the low byte
            pos = int'(cmd_len(k)) - 1 - i;
            if (pos < 0) begin
                pos = 0;
            end
            return s[BYTE_W*pos +: BYTE_W];
        end
    endfunction

endpackage

>>> hw/rtl/scl_front.sv
// scl_front: input stage, registers each received byte with its kind
// depends on scl_pkg
module scl_front
    import scl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              item_valid,
    input  logic              item_ready,
    output item_t             item
);

    logic  valid_reg;
    item_t item_reg;
    kind_t kind;

    always_comb begin
        if (in_byte == BYTE_LF || in_byte == BYTE_CR) begin
            kind = KIND_EOL;
        end else if (in_byte == BYTE_DEL) begin
            kind = KIND_DEL;
        end else begin
            kind = KIND_CHAR;
        end
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            item_reg.kind <= kind;
            item_reg.data <= in_byte;
        end
    end

endmodule

>>> hw/rtl/scl_queue.sv
// scl_queue: short item queue between front and back end
// depends on scl_pkg
module scl_queue
    import scl_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   fill_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (fill_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/scl_back.sv
// scl_back: line buffer, character count, command compare and result register
// depends on scl_pkg
module scl_back
    import scl_pkg::*;
#(
    parameter int MAX_LINE_LENGTH = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int DEPTH = MAX_LINE_LENGTH + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_LINE_LENGTH + 2);

    logic [BYTE_W-1:0] line_reg [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     eff_count;
    logic              res_valid_reg;
    result_t           res_reg;
    result_t           res_next;
    logic              do_pop;
    logic [NUM_CMDS-1:0] hit;
    logic              chars_eq;
    logic              len_eq;

    assign item_ready = !res_valid_reg || res_ready;
    assign do_pop     = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // an overlong line restarts at position zero
    assign eff_count = (count_reg > CW'(MAX_LINE_LENGTH)) ? '0 : count_reg;

    // a command hits when its characters lead the line and the line ends
    // right after them, either by the count or by a stored zero byte
    always_comb begin
        hit = '0;
        for (int k = 0; k < NUM_CMDS; k++) begin
            chars_eq = 1'b1;
            for (int i = 0; i < CMD_MAX_CHARS; i++) begin
                if (i < int'(cmd_len(k)) && line_reg[i] != cmd_char(k, i)) begin
                    chars_eq = 1'b0;
                end
            end
            len_eq = (eff_count == CW'(cmd_len(k))) ||
                     ((eff_count > CW'(cmd_len(k))) &&
                      (line_reg[AW'(cmd_len(k))] == '0));
            hit[k] = chars_eq && len_eq;
        end
    end

    // lowest table position wins
    always_comb begin
        res_next = '0;
        for (int k = NUM_CMDS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                res_next.matched       = 1'b1;
                res_next.command_index = CMD_IDX_W'(k);
            end
        end
    end

    always_comb begin
        case (item.kind)
            KIND_EOL: count_next = '0;
            KIND_DEL: count_next = (eff_count != '0) ? eff_count - 1'b1 : '0;
            default:  count_next = eff_count + 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (do_pop && item.kind == KIND_EOL) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (do_pop) begin
                count_reg <= count_next;
            end
        end
        // terminators are never read back, only ordinary bytes are stored
        if (do_pop && item.kind == KIND_CHAR) begin
            line_reg[eff_count[AW-1:0]] <= item.data;
        end
        if (do_pop && item.kind == KIND_EOL) begin
            res_reg <= res_next;
        end
    end

endmodule

>>> hw/rtl/serial_command_line_matcher.sv
// serial_command_line_matcher: top level, front stage, item queue and back end
// depends on scl_pkg, scl_front, scl_queue, scl_back
// throughput: one byte per cycle while no result waits; a line end byte passes the
// front register, queue, result register; the back end executes one item a cycle
// reset: synchronous active low aresetn empties the queue and clears the count;
// line buffer contents are left as they are and never read before being written
module serial_command_line_matcher
    import scl_pkg::*;
#(
    parameter int MAX_LINE_LENGTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    // received bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    // line results
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [4:1] command_index, [7:5] zero
);

    // classified item from the front stage into the queue
    logic    fr_valid;
    logic    fr_ready;
    item_t   fr_item;

    // queue head into the back end
    logic    bk_valid;
    logic    bk_ready;
    item_t   bk_item;

    result_t result;

    // front: registers and classifies each byte (line end, delete, ordinary)
    scl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    // short queue so the front keeps taking items while the result waits
    scl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_item   (bk_item)
    );

    // back: updates the line buffer and count, compares on line end
    scl_back #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (bk_valid),
        .item_ready (bk_ready),
        .item       (bk_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (result)
    );

    // result packed from the low bit up, padded to a byte
    assign m_tdata = {3'b000, result.command_index, result.matched};

endmodule

>>> verif/testbench.sv
// testbench for serial_command_line_matcher: drives received bytes, predicts
// the verdict of each finished line and checks every result item in order
// depends on scl_pkg and the serial_command_line_matcher rtl
`timescale 1ns / 100ps

module testbench
    import scl_pkg::*;
();

    localparam int LINE_MAX         = 16;      // line length the block is built for
    localparam int RANDOM_BYTES     = 1700;    // random items after the directed part
    localparam int QUIET_TAIL       = 200;     // last items run with no idling at all
    localparam int LONG_HOLD_CYCLES = 100;     // receiver hold-off that backs up the pipe
    localparam int SETTLE_CYCLES    = 8;       // margin past the front, queue and result registers
    localparam int END_WAIT_CYCLES  = 5000;
    localparam int TIMEOUT_NS       = 400000;

    // predicts the verdict of each line from the accepted bytes and keeps
    // the verdicts that have not come out of the block yet
    class line_verdict_board;
        string      cmd_text [NUM_CMDS];
        logic [7:0] line_buf [LINE_MAX+1];
        int         count;
        result_t    pending_verdicts [$];
        int         mismatches;

        function new();
            cmd_text = '{"Reset", "Get Sample", "G", "Init ADC", "Status ADC",
                         "Calib ADC", "Reset ADC", "4", "1", "5", "2", "Time",
                         "Set UART", "Help"};
            foreach (line_buf[i]) begin
                line_buf[i] = 8'h00;
            end
            count      = 0;
            mismatches = 0;
        endfunction

        task report(input string what);
            $display("%0t mismatch: %s", $time, what);
            mismatches++;
        endtask

        // one accepted byte; a line end queues the verdict it must give
        function void note_byte(input logic [7:0] b);
            int      len;
            int      k;
            int      i;
            bit      same;
            result_t verdict;
            // an overlong line starts over from the first position
            if (count > LINE_MAX) begin
                count = 0;
            end
            line_buf[count] = b;
            if (b == BYTE_LF || b == BYTE_CR) begin
                line_buf[count] = 8'h00;
                // the compared line stops at the first zero byte
                len = 0;
                while (len < count && line_buf[len] != 8'h00) begin
                    len++;
                end
                count   = 0;
                verdict = '0;
                // walk the table backwards so the lowest matching entry wins
                for (k = NUM_CMDS - 1; k >= 0; k--) begin
                    same = (cmd_text[k].len() == len);
                    for (i = 0; i < len && same; i++) begin
                        if (line_buf[i] != cmd_text[k][i]) begin
                            same = 0;
                        end
                    end
                    if (same) begin
                        verdict.matched       = 1'b1;
                        verdict.command_index = k[CMD_IDX_W-1:0];
                    end
                end
                pending_verdicts.push_back(verdict);
            end else if (b == BYTE_DEL) begin
                // delete never takes the count below zero
                line_buf[count] = 8'h00;
                if (count > 0) begin
                    count--;
                end
            end else begin
                count++;
            end
        endfunction

        // one accepted result item against the oldest verdict waiting
        task check_verdict(input logic [7:0] data);
            result_t want;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("result 0x%02h with no line end waiting", data));
            end else begin
                want = pending_verdicts.pop_front();
                if (data[0] !== want.matched) begin
                    report($sformatf("matched %b, wanted %b", data[0], want.matched));
                end
                if (data[4:1] !== want.command_index) begin
                    report($sformatf("command_index %0d, wanted %0d",
                                     data[4:1], want.command_index));
                end
                if (data[7:5] !== 3'b000) begin
                    report($sformatf("pad bits %b not zero", data[7:5]));
                end
            end
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] rx_byte
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [0] matched, [4:1] command_index, [7:5] zero

    logic idle_enable;      // random idle bursts on both sides
    logic hold_request;     // asks the receiver for one long hold-off
    int   bytes_sent;

    line_verdict_board verdicts = new();

    serial_command_line_matcher #(
        .MAX_LINE_LENGTH(LINE_MAX)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever begin
            #1 aclk = ~aclk;
        end
    end

    // hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("serial_command_line_matcher test failed");
        $finish;
    end

    // one item: optional idle burst, then hold valid until the block takes it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        verdicts.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? BYTE_LF : BYTE_CR;
    endfunction

    function automatic logic [7:0] any_printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // sender stops until every verdict is out, then lets the pipe settle
    task automatic wait_all_verdicts();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (verdicts.pending_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one random line, mostly commands with edits, the rest noise
    task automatic send_random_line();
        int    kind;
        int    k;
        int    n;
        int    i;
        int    pos;
        string s;
        kind = $urandom_range(0, 99);
        k    = $urandom_range(0, NUM_CMDS - 1);
        s    = verdicts.cmd_text[k];
        if (kind < 45) begin
            // clean command, now and then a typo taken back with delete
            for (i = 0; i < s.len(); i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_byte(any_printable());
                    send_byte(BYTE_DEL);
                end
                send_byte(s[i]);
            end
            send_byte(line_end());
        end else if (kind < 60) begin
            // near miss: one char changed, case flipped, cut short or one extra
            pos = $urandom_range(0, s.len() - 1);
            n   = s.len();
            case ($urandom_range(0, 3))
                0: s.putc(pos, any_printable());
                1: s.putc(pos, s[pos] ^ 8'h20);
                2: n = s.len() - 1;
                default: begin
                    s = {s, string'(any_printable())};
                    n = s.len();
                end
            endcase
            if (n == s.len()) begin
                send_text(s);
            end else begin
                for (i = 0; i < n; i++) begin
                    send_byte(s[i]);
                end
            end
            send_byte(line_end());
        end else if (kind < 70) begin
            // overlong line, often exactly long enough to wrap, then maybe a command
            n = $urandom_range(0, 1) ? LINE_MAX + 1
                                     : $urandom_range(LINE_MAX - 2, LINE_MAX + 4);
            for (i = 0; i < n; i++) begin
                send_byte(any_printable());
            end
            if ($urandom_range(0, 1) == 1) begin
                send_text(s);
            end
            send_byte(line_end());
        end else if (kind < 78) begin
            // zero byte cuts the compared line short
            send_text(s);
            send_byte(8'h00);
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(0, 255)));
            end
            send_byte(line_end());
        end else if (kind < 86) begin
            // more deletes than characters, then maybe a command
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++) begin
                send_byte(any_printable());
            end
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
                send_byte(BYTE_DEL);
            end
            if ($urandom_range(0, 1) == 1) begin
                send_text(s);
            end
            send_byte(line_end());
        end else begin
            // raw bytes over the full range, line end only half the time
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1) begin
                send_byte(line_end());
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial begin : receiver
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 7) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            verdicts.check_verdict(m_tdata);
        end
    end

    initial begin : stimulus
        int i;
        int first;
        int tail;
        bit paused;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        idle_enable  = 1'b1;
        hold_request = 1'b0;
        bytes_sent   = 0;
        paused       = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty line right after reset
        send_byte(BYTE_LF);
        // delete on an empty line stays at zero
        send_byte(BYTE_DEL);
        send_byte(BYTE_DEL);
        send_byte(BYTE_CR);
        // zero byte ends the compared line, so this is still a match
        send_byte("G");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(BYTE_LF);
        // typo removed by delete before the line end
        send_byte("4");
        send_byte("X");
        send_byte(BYTE_DEL);
        send_byte(BYTE_CR);
        // top byte value, deleted, then a one char command
        send_byte(8'hFF);
        send_byte(BYTE_DEL);
        send_byte("2");
        send_byte(BYTE_LF);
        wait_all_verdicts();

        // receiver holds off while short lines keep coming, input must stall
        @(posedge aclk);
        hold_request = 1'b1;
        for (i = 0; i < 12; i++) begin
            send_byte("1");
            send_byte(line_end());
        end
        wait_all_verdicts();

        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            if (bytes_sent - first > RANDOM_BYTES - QUIET_TAIL) begin
                idle_enable = 1'b0;
            end
            // one pause halfway until the block has caught up
            if (!paused && bytes_sent - first > RANDOM_BYTES / 2) begin
                paused = 1;
                wait_all_verdicts();
            end
            send_random_line();
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        tail = 0;
        while (verdicts.pending_verdicts.size() != 0 && tail < END_WAIT_CYCLES) begin
            @(posedge aclk);
            tail++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (verdicts.pending_verdicts.size() != 0) begin
            verdicts.report($sformatf("%0d line verdicts never came out",
                                      verdicts.pending_verdicts.size()));
        end
        if (verdicts.mismatches == 0) begin
            $display("serial_command_line_matcher test passed");
        end else begin
            $display("serial_command_line_matcher test failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/scl_pkg.sv
hw/rtl/scl_front.sv
hw/rtl/scl_queue.sv
hw/rtl/scl_back.sv
hw/rtl/serial_command_line_matcher.sv
verif/testbench.sv
